@@ rtl/pcg32_pkg.sv @@
// pcg32_pkg: shared types, constants and the xsh-rr output function
// used by the pcg32 generator top level and its serial arithmetic units
// no dependencies
package pcg32_pkg;

    localparam logic [63:0] LCG_MULT      = 64'h5851_F42D_4C95_7F2D;
    localparam logic [63:0] DEFAULT_STATE = 64'h0000_0000_BA5E_BA11;

    localparam int XSH_SHIFT_A = 18;
    localparam int XSH_SHIFT_B = 27;
    localparam int ROT_LSB     = 59;

    localparam int APB_AW = 4;
    localparam logic [APB_AW-1:0] ADDR_SEED = 4'h0;
    localparam logic [APB_AW-1:0] ADDR_SEQ  = 4'h8;

    typedef enum logic [1:0] {
        CMD_RAW     = 2'd0,
        CMD_BOUNDED = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DONE
    } state_t;

    // xorshift high bits, then rotate right by the top five state bits
    function automatic logic [31:0] xsh_rr(input logic [63:0] old);
        logic [31:0] mixed;
        logic [4:0]  rot;
        begin
            mixed = 32'(((old >> XSH_SHIFT_A) ^ old) >> XSH_SHIFT_B);
            rot   = old[63:ROT_LSB];
            xsh_rr = (mixed >> rot) | (mixed << 5'(5'd0 - rot));
        end
    endfunction

endpackage

@@ rtl/pcg32_random_generator.sv @@
// pcg32_random_generator: pcg32 xsh-rr generator with bounded and restart commands
// top level, apb register port, command sequencer and response register
// depends on pcg32_pkg, pcg32_lcg_mul, pcg32_mod_div
//
//   channel   handshake              payload                   direction
//   req       req_valid / req_stall  command, bound            into block
//   rsp       rsp_valid / rsp_stall  random_word, bound_error  out of block
//   apb       psel / penable / pready paddr, pwdata, prdata    register access
//
// raw and bounded transactions pass through the busy state until both units are idle:
// the radix-4 serial multiplier needs a setup step and 32 digit steps,
// the bit-serial remainder (32 steps) runs alongside it
// restart and unused commands skip the units and go straight to the done state
// reset (rst_n low, asynchronous) loads state and seed with 0xBA5EBA11
// and clears the sequence selector; one transaction is in flight at a time,
// and a finished response waits in its register while the next is accepted
module pcg32_random_generator
    import pcg32_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [1:0]        command,
    input  logic [31:0]       bound,
    // response channel
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [31:0]       random_word,
    output logic              bound_error,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    state_t      state_reg;
    state_t      state_next;

    logic [63:0] gen_state_reg;
    logic [63:0] seed_reg;
    logic [63:0] seq_reg;
    cmd_t        cmd_reg;
    logic        bound_zero_reg;
    logic [31:0] word_reg;

    logic        rsp_valid_reg;
    logic [31:0] rsp_word_reg;
    logic        rsp_err_reg;
    logic [31:0] rsp_word_next;
    logic        rsp_err_next;

    cmd_t        cmd_in;
    logic        req_accept;
    logic        rsp_take;
    logic        start_mul;
    logic        start_div;
    logic        units_idle;
    logic        load_rsp;
    logic        apb_write;

    logic        mul_busy;
    logic [63:0] mul_product;
    logic        div_busy;
    logic [31:0] div_rem;

    // handshakes
    assign cmd_in     = cmd_t'(command);
    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_take   = rsp_valid_reg && !rsp_stall;
    assign units_idle = !mul_busy && !div_busy;

    // both word commands advance the state; only bounded needs the remainder
    assign start_mul = req_accept && (cmd_in == CMD_RAW || cmd_in == CMD_BOUNDED);
    assign start_div = req_accept && (cmd_in == CMD_BOUNDED);

    // register port, writes complete in the access phase
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr)
            ADDR_SEED: prdata = seed_reg;
            ADDR_SEQ:  prdata = seq_reg;
            default:   prdata = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load_rsp   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = start_mul ? ST_BUSY : ST_DONE;
                end
            end
            ST_BUSY:
            begin
                if (units_idle)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // response register free or emptied this cycle
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_rsp   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result selection from the finished transaction
    always_comb
    begin
        rsp_word_next = '0;
        rsp_err_next  = 1'b0;
        case (cmd_reg)
            CMD_RAW:
            begin
                rsp_word_next = word_reg;
            end
            CMD_BOUNDED:
            begin
                rsp_err_next  = bound_zero_reg;
                rsp_word_next = bound_zero_reg ? 32'd0 : div_rem;
            end
            default:
            begin
                rsp_word_next = '0;
            end
        endcase
    end

    // generator state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state_reg <= DEFAULT_STATE;
            seed_reg      <= DEFAULT_STATE;
            seq_reg       <= '0;
        end
        else
        begin
            if (apb_write && paddr == ADDR_SEED)
            begin
                seed_reg <= pwdata;
            end
            if (apb_write && paddr == ADDR_SEQ)
            begin
                seq_reg <= pwdata;
            end
            if (req_accept && cmd_in == CMD_RESTART)
            begin
                gen_state_reg <= seed_reg;
            end
            else if (state_reg == ST_BUSY && units_idle)
            begin
                gen_state_reg <= mul_product;
            end
        end
    end

    // transaction capture; output word comes from the old state
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            cmd_reg        <= cmd_in;
            bound_zero_reg <= (bound == 32'd0);
            word_reg       <= xsh_rr(gen_state_reg);
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load_rsp)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_take)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_word_reg <= rsp_word_next;
            rsp_err_reg  <= rsp_err_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign random_word = rsp_word_reg;
    assign bound_error = rsp_err_reg;

    // serial arithmetic units
    pcg32_lcg_mul u_lcg_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_mul),
        .old_state (gen_state_reg),
        .increment (seq_reg | 64'd1),
        .busy      (mul_busy),
        .product   (mul_product)
    );

    pcg32_mod_div u_mod_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_div),
        .dividend  (xsh_rr(gen_state_reg)),
        .divisor   (bound),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    // checks
    a_restart_load: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && cmd_in == CMD_RESTART |=> gen_state_reg == $past(seed_reg))
        else $error("restart did not load seed");

    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mul_busy && !div_busy)
        else $error("arithmetic unit busy while sequencer idle");

    a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
        start_mul |=> mul_busy && state_reg == ST_BUSY)
        else $error("multiplier not running after word request");

    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_err_reg |-> rsp_word_reg == 32'd0)
        else $error("bound error with nonzero word");

endmodule

@@ rtl/pcg32_lcg_mul.sv @@
// pcg32_lcg_mul: radix-4 serial multiply-add, state * LCG_MULT + increment
// one two-bit digit of the constant per cycle after a setup step
// depends on pcg32_pkg
module pcg32_lcg_mul
    import pcg32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] old_state,
    input  logic [63:0] increment,
    output logic        busy,
    output logic [63:0] product
);

    logic        busy_reg;
    logic        prep_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [63:0] x1_reg;
    logic [63:0] x3_reg;
    logic [63:0] mdig_reg;
    logic [63:0] addend;

    always_comb
    begin
        case (mdig_reg[1:0])
            2'd1:    addend = x1_reg;
            2'd2:    addend = {x1_reg[62:0], 1'b0};
            2'd3:    addend = x3_reg;
            default: addend = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            prep_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            prep_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (prep_reg)
        begin
            prep_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= increment;
            x1_reg   <= old_state;
            mdig_reg <= LCG_MULT;
        end
        else if (prep_reg)
        begin
            x3_reg <= x1_reg + {x1_reg[62:0], 1'b0};
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_reg + addend;
            x1_reg   <= {x1_reg[61:0], 2'b00};
            x3_reg   <= {x3_reg[61:0], 2'b00};
            mdig_reg <= {2'b00, mdig_reg[63:2]};
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

@@ rtl/pcg32_mod_div.sv @@
// pcg32_mod_div: restoring serial remainder, one dividend bit per cycle
// 32 steps give dividend modulo divisor
// depends on pcg32_pkg
module pcg32_mod_div
    import pcg32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] remainder
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [31:0] dsr_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic [31:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[31]};
        diff  = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = diff[31:0];
        end
        else
        begin
            rem_next = trial[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[30:0], 1'b0};
        end
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

@@ bench/pcg32_response_checker.sv @@
// pcg32_response_checker: watches the request, response and register channels of the
// pcg32 generator, predicts every response and compares it field by field
// depends on pcg32_pkg for the command codes and register addresses
module pcg32_response_checker
    import pcg32_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  logic [1:0]        command,
    input  logic [31:0]       bound,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  logic [31:0]       random_word,
    input  logic              bound_error,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [63:0]       pwdata,
    output int                mismatch_count,
    output int                words_pending,
    output int                words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic        err;
    } pcg_result_t;

    localparam logic [63:0] LCG_MULTIPLIER = 64'd6364136223846793005;
    localparam logic [63:0] POWER_ON_STATE = 64'h0000_0000_BA5E_BA11;

    logic [63:0] lcg_state;
    logic [63:0] seed_reg;
    logic [63:0] stream_reg;
    pcg_result_t expected_words[$];
    int          fails;
    int          checked;

    // advance the lcg and return the permuted word of the old state
    function automatic logic [31:0] step_lcg();
        logic [63:0] prev;
        logic [31:0] mixed;
        logic [4:0]  rot;
        prev      = lcg_state;
        lcg_state = prev * LCG_MULTIPLIER + (stream_reg | 64'd1);
        mixed     = 32'(((prev >> 18) ^ prev) >> 27);
        rot       = prev[63:59];
        // a shift by 32 clears the word, so rot of zero needs no special case
        return (mixed >> rot) | (mixed << (6'd32 - rot));
    endfunction

    function automatic pcg_result_t predict_word(input logic [1:0] cmd, input logic [31:0] bnd);
        pcg_result_t r;
        logic [31:0] w;
        r = '0;
        case (cmd)
            CMD_RAW:     r.word = step_lcg();
            CMD_BOUNDED:
            begin
                w = step_lcg();
                if (bnd == 32'd0)
                    r.err = 1'b1;
                else
                    r.word = w % bnd;
            end
            CMD_RESTART: lcg_state = seed_reg;
            default:     ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pcg_result_t want;
        if (!rst_n)
        begin
            lcg_state  = POWER_ON_STATE;
            seed_reg   = POWER_ON_STATE;
            stream_reg = 64'd0;
            expected_words.delete();
            fails      = 0;
            checked    = 0;
            mismatch_count <= 0;
            words_pending  <= 0;
            words_checked  <= 0;
        end
        else
        begin
            // response first: a new request at the same edge queues behind it
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("response with no transaction outstanding: random_word %h bound_error %b",
                           random_word, bound_error);
                    fails++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    checked++;
                    if (random_word !== want.word)
                    begin
                        $error("random_word mismatch: expected %h, actual %h",
                               want.word, random_word);
                        fails++;
                    end
                    if (bound_error !== want.err)
                    begin
                        $error("bound_error mismatch: expected %b, actual %b",
                               want.err, bound_error);
                        fails++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_SEED: seed_reg   = pwdata;
                    ADDR_SEQ:  stream_reg = pwdata;
                    default:   ;
                endcase
            end
            if (req_valid && !req_stall)
                expected_words.push_back(predict_word(command, bound));
            mismatch_count <= fails;
            words_pending  <= expected_words.size();
            words_checked  <= checked;
        end
    end

endmodule

@@ bench/tb_pcg32_random_generator.sv @@
// tb_pcg32_random_generator: stimulus and verdict for the pcg32 generator
// drives requests and register writes, stalls the response side at random
// depends on pcg32_pkg, pcg32_random_generator and pcg32_response_checker
module tb_pcg32_random_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import pcg32_pkg::*;

    // code outside the enum, the block must answer it with a zero result
    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    // worst quiet stretch is about a long gap, a full multiply and a long stall
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         NUM_PHASES      = 5;
    localparam int         ITEMS_PER_PHASE = 106;
    // restart skips the serial units, every request answers,
    // so a short settle is enough
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         TAIL_CYCLES     = 40;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic [1:0]        command   = CMD_RAW;
    logic [31:0]       bound     = 32'd0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    logic [31:0]       random_word;
    logic              bound_error;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [63:0]       pwdata    = '0;
    logic [63:0]       prdata;
    logic              pready;

    int mismatch_count;
    int words_pending;
    int words_checked;

    // coverage tallies for the closing summary
    int n_raw        = 0;
    int n_bounded    = 0;
    int n_zero_bound = 0;
    int n_restart    = 0;
    int n_unused     = 0;
    int n_settings   = 0;

    int quiet_cycles = 0;
    int stall_run    = 0;
    int stall_pick;

    always #5 clk = ~clk;

    pcg32_random_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .command     (command),
        .bound       (bound),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .random_word (random_word),
        .bound_error (bound_error),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pcg32_response_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .command        (command),
        .bound          (bound),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .random_word    (random_word),
        .bound_error    (bound_error),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending),
        .words_checked  (words_checked)
    );

    // response back-pressure: runs of free flow, short blips and the odd long
    // stall that can outlast a whole multiply, so stalls land on every phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run != 0)
        begin
            stall_run <= stall_run - 1;
        end
        else
        begin
            stall_pick = $urandom_range(0, 9);
            if (stall_pick < 6)
            begin
                rsp_stall <= 1'b0;
                // pick 0 can give a long stretch with no stalls at all
                stall_run <= $urandom_range(0, (stall_pick == 0) ? 120 : 12);
            end
            else
            begin
                rsp_stall <= 1'b1;
                stall_run <= (stall_pick == 9) ? $urandom_range(20, 45) : $urandom_range(0, 3);
            end
        end
    end

    // watchdog: any accepted transaction on any channel counts as progress
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_pcg32_random_generator NOT OK");
            $finish;
        end
    end

    // present one request and hold it until accepted; valid stays high so a
    // burst can continue straight on from the accepting edge
    task automatic issue(input logic [1:0] cmd, input logic [31:0] bnd);
        req_valid <= 1'b1;
        command   <= cmd;
        bound     <= bnd;
        do
            @(posedge clk);
        while (req_stall);
        case (cmd)
            CMD_RAW:     n_raw++;
            CMD_BOUNDED:
            begin
                n_bounded++;
                if (bnd == 32'd0)
                    n_zero_bound++;
            end
            CMD_RESTART: n_restart++;
            default:     n_unused++;
        endcase
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // wait until every expected response has been taken; the first edge lets
    // the checker see the last accepted request before its count is read
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // registers change only with the generator idle
    task automatic load_settings(input logic [63:0] seed, input logic [63:0] stream);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        reg_write(ADDR_SEED, seed);
        reg_write(ADDR_SEQ, stream);
        n_settings++;
    endtask

    // moduli: zero, tiny, powers of two, near the top, and fully random
    function automatic logic [31:0] random_modulus();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1, 2:    return $urandom_range(1, 16);
            3:       return 32'd1 << $urandom_range(0, 31);
            4:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            5:       return {1'b1, 31'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // back-to-back often, short gaps mostly, and now and then a gap
    // that can outlast a full multiply
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 8);
        else
            return $urandom_range(20, 45);
    endfunction

    initial
    begin
        logic [63:0] seeds   [NUM_PHASES];
        logic [63:0] streams [NUM_PHASES];
        int          placed;
        int          burst;
        int          roll;

        // extremes first, then random settings; streams 0, 3 and 4 have bit 0 clear
        // so the forced odd increment matters
        seeds[0]   = 64'd0;
        streams[0] = 64'd0;
        seeds[1]   = '1;
        streams[1] = '1;
        seeds[2]   = {$urandom, $urandom};
        streams[2] = {$urandom, $urandom};
        seeds[3]   = {$urandom, $urandom};
        streams[3] = {$urandom, $urandom} & ~64'd1;
        seeds[4]   = {$urandom, $urandom};
        streams[4] = 64'd0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass on the power-on settings: raw words with extreme
        // bound fields, the modulo corners, zero bound, restart and the unused code
        issue(CMD_RAW, 32'd0);
        issue(CMD_RAW, 32'hFFFF_FFFF);
        issue(CMD_BOUNDED, 32'd0);
        issue(CMD_BOUNDED, 32'd1);
        issue(CMD_BOUNDED, 32'd2);
        issue(CMD_BOUNDED, 32'hFFFF_FFFF);
        issue(CMD_BOUNDED, 32'h8000_0000);
        issue(CMD_BOUNDED, 32'd7);
        issue(CMD_RESTART, 32'd0);
        issue(CMD_RESTART, 32'hFFFF_FFFF);
        issue(CMD_RAW, 32'h5555_5555);
        issue(CMD_UNUSED, 32'hFFFF_FFFF);
        issue(CMD_UNUSED, 32'd0);
        issue(CMD_RAW, 32'd0);
        pause(3);
        issue(CMD_BOUNDED, 32'hAAAA_AAAA);
        issue(CMD_BOUNDED, 32'd0);
        issue(CMD_RAW, 32'd0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            load_settings(seeds[p], streams[p]);
            placed = 0;
            while (placed < ITEMS_PER_PHASE)
            begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 42)
                    begin
                        issue(CMD_RAW, $urandom);
                        placed++;
                    end
                    else if (roll < 84)
                    begin
                        issue(CMD_BOUNDED, random_modulus());
                        placed++;
                    end
                    else if (roll < 94)
                    begin
                        issue(CMD_RESTART, $urandom);
                        placed++;
                    end
                    else
                    begin
                        // unused code changes nothing, so it is not counted
                        issue(CMD_UNUSED, $urandom);
                    end
                end
                pause(gap_length());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d raw, %0d bounded (%0d zero bound), %0d restart, %0d unused code",
                 n_raw, n_bounded, n_zero_bound, n_restart, n_unused);
        $display("over %0d register settings plus power-on; %0d responses compared, %0d errors",
                 n_settings, words_checked, mismatch_count);
        if (mismatch_count == 0 && words_pending == 0)
            $display("tb_pcg32_random_generator OK");
        else
            $display("tb_pcg32_random_generator NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pcg32_pkg.sv
rtl/pcg32_lcg_mul.sv
rtl/pcg32_mod_div.sv
rtl/pcg32_random_generator.sv
bench/pcg32_response_checker.sv
bench/tb_pcg32_random_generator.sv
